// File: sv/pecd_pkg.sv
// ----------------------------------------------------------------------------
// pecd_pkg
// Types and constants for the printer escape code decoder.
// ----------------------------------------------------------------------------
package pecd_pkg;

  localparam int unsigned MAX_OUT   = 256;
  localparam int unsigned COUNT_CAP = (MAX_OUT > 511) ? 511 : MAX_OUT;
  localparam logic [8:0]  COUNT_MAX = 9'(COUNT_CAP);

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ESC   = 8'd27;
  localparam logic [7:0] CH_TILDE = 8'h7E;
  localparam logic [7:0] CH_CARET = 8'h5E;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_H     = 8'h48;
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_Z     = 8'h5A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef enum logic [2:0] {
    MODE_NORMAL = 3'd0,
    MODE_BSL    = 3'd1,
    MODE_CARET  = 3'd2,
    MODE_DIG1   = 3'd3,
    MODE_DIG2   = 3'd4
  } mode_t;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_EOL_BSL   = 3'd1,
    ERR_BAD_HEX   = 3'd2,
    ERR_BAD_DEC   = 3'd3,
    ERR_BAD_CARET = 3'd4
  } err_t;

  function automatic logic [7:0] upper8(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h61 && c <= 8'h7A) begin
      r = c - 8'h20;
    end
    return r;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

endpackage

// File: sv/printer_escape_code_decoder.sv
// ----------------------------------------------------------------------------
// printer_escape_code_decoder
// Translates printer control-code strings into printer bytes, one source
// character per request, one result per request.
// ----------------------------------------------------------------------------
//  channel  | handshake           | payload
//  ---------+---------------------+----------------------------------------------
//  input    | in_valid, in_ready  | src_char
//  output   | out_valid,out_ready | byte_valid, out_byte, string_done,
//           |                     | error_code, byte_count
//
//  One request per cycle unless the result stalls; input, then result register.
//  Escape state advances as a request moves from the input to the result register.
//  Reset clears the decode mode, held digits, byte count and both valid flags.
//  A stalled result holds the result register; the input register still fills,
//  then in_ready drops until the result is taken.
// ----------------------------------------------------------------------------
module printer_escape_code_decoder
  import pecd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] src_char,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       byte_valid,
  output logic [7:0] out_byte,
  output logic       string_done,
  output logic [2:0] error_code,
  output logic [8:0] byte_count
);

  logic       held_valid;
  logic [7:0] held_char;
  logic       advance;

  mode_t      mode, mode_next;
  logic [3:0] first_digit, first_digit_next;
  logic [7:0] second_char, second_char_next;
  logic [8:0] emitted_count, emitted_count_next;

  logic       eol;
  logic [7:0] c_up;
  logic [7:0] s_up;
  logic [3:0] d_val;
  logic [3:0] s_dec;
  logic [4:0] hex_lo;
  logic [9:0] dec_sum;
  logic       r_valid;
  logic [7:0] r_byte;
  err_t       r_err;
  logic [8:0] r_count;

  assign advance  = held_valid && (!out_valid || out_ready);
  assign in_ready = !held_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      held_char <= src_char;
    end
  end

  assign eol     = (held_char == CH_NUL) || (held_char == CH_LF);
  assign c_up    = upper8(held_char);
  assign s_up    = upper8(second_char);
  assign d_val   = 4'(held_char - CH_ZERO);
  assign s_dec   = 4'(second_char - CH_ZERO);
  assign hex_lo  = is_digit(s_up) ? 5'(s_up - CH_ZERO) : 5'(s_up - CH_A + 8'd10);
  assign dec_sum = 10'(first_digit) * 10'd100 + 10'(s_dec) * 10'd10 + 10'(d_val);

  always_comb begin
    mode_next = mode;
    if (eol) begin
      mode_next = MODE_NORMAL;
    end else begin
      case (mode)
        MODE_BSL: begin
          mode_next = is_digit(held_char) ? MODE_DIG1 : MODE_NORMAL;
        end
        MODE_DIG1: begin
          mode_next = MODE_DIG2;
        end
        MODE_CARET, MODE_DIG2: begin
          mode_next = MODE_NORMAL;
        end
        default: begin
          if (held_char == CH_BSL) begin
            mode_next = MODE_BSL;
          end else if (held_char == CH_CARET) begin
            mode_next = MODE_CARET;
          end else begin
            mode_next = MODE_NORMAL;
          end
        end
      endcase
    end
  end

  always_comb begin
    r_valid          = 1'b0;
    r_byte           = 8'h00;
    r_err            = ERR_NONE;
    first_digit_next = first_digit;
    second_char_next = second_char;
    if (eol) begin
      r_valid = 1'b1;
      case (mode)
        MODE_BSL:             r_err = ERR_EOL_BSL;
        MODE_CARET:           r_err = ERR_BAD_CARET;
        MODE_DIG1, MODE_DIG2: r_err = ERR_BAD_DEC;
        default:              r_err = ERR_NONE;
      endcase
    end else begin
      case (mode)
        MODE_BSL: begin
          if (is_digit(held_char)) begin
            first_digit_next = d_val;
          end else begin
            r_valid = 1'b1;
            r_byte  = held_char;
          end
        end
        MODE_CARET: begin
          if (c_up >= CH_A && c_up <= CH_Z) begin
            r_valid = 1'b1;
            r_byte  = c_up - CH_A + 8'd1;
          end else begin
            r_err = ERR_BAD_CARET;
          end
        end
        MODE_DIG1: begin
          second_char_next = held_char;
        end
        MODE_DIG2: begin
          if (c_up == CH_H) begin
            if (is_digit(s_up) || (s_up >= CH_A && s_up <= CH_H)) begin
              r_valid = 1'b1;
              r_byte  = {first_digit, 4'h0} + 8'(hex_lo);
            end else begin
              r_err = ERR_BAD_HEX;
            end
          end else if (is_digit(second_char) && is_digit(held_char)) begin
            r_valid = 1'b1;
            r_byte  = dec_sum[7:0];
          end else begin
            r_err = ERR_BAD_DEC;
          end
        end
        default: begin
          if (held_char == CH_TILDE) begin
            r_valid = 1'b1;
            r_byte  = CH_ESC;
          end else if (held_char != CH_SPACE && held_char != CH_BSL &&
                       held_char != CH_CARET) begin
            r_valid = 1'b1;
            r_byte  = held_char;
          end
        end
      endcase
    end
  end

  assign r_count = (r_valid && emitted_count < COUNT_MAX) ? emitted_count + 9'd1
                                                          : emitted_count;
  assign emitted_count_next = eol ? 9'd0 : r_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= MODE_NORMAL;
      first_digit   <= 4'd0;
      second_char   <= 8'd0;
      emitted_count <= 9'd0;
      out_valid     <= 1'b0;
    end else begin
      if (advance) begin
        mode          <= mode_next;
        first_digit   <= first_digit_next;
        second_char   <= second_char_next;
        emitted_count <= emitted_count_next;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
    if (advance) begin
      byte_valid  <= r_valid;
      out_byte    <= r_byte;
      string_done <= eol;
      error_code  <= r_err;
      byte_count  <= r_count;
    end
  end

endmodule
